### rtl/core/ucse_pkg.sv
package ucse_pkg;

  // Output encodings selected by the configuration register.
  localparam logic [1:0] ENC_LATIN1 = 2'd0;
  localparam logic [1:0] ENC_LATIN9 = 2'd1;
  localparam logic [1:0] ENC_XML    = 2'd2;
  localparam logic [1:0] ENC_UTF8   = 2'd3;

  localparam int BIN_BITS   = 31;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_BITS   = 4 * BCD_DIGITS;
  localparam int MAX_SEQ    = 13;

  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;

  localparam logic signed [31:0] LATIN_MAX     = 32'sh0000_00FF;
  localparam logic signed [31:0] XML_NUM_START = 32'sh0000_007F;
  localparam logic signed [31:0] UTF8_MAX1     = 32'sh0000_007F;
  localparam logic signed [31:0] UTF8_MAX2     = 32'sh0000_07FF;
  localparam logic signed [31:0] UTF8_MAX3     = 32'sh0000_FFFF;
  localparam logic signed [31:0] UTF8_MAX4     = 32'sh001F_FFFF;
  localparam logic signed [31:0] UTF8_MAX5     = 32'sh03FF_FFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_SINGLE,
    K_ENTITY,
    K_NUMERIC,
    K_UTF8
  } kind_t;

  typedef enum logic [2:0] {
    E_LT,
    E_GT,
    E_AMP,
    E_APOS,
    E_QUOT
  } ent_t;

  // Everything the byte selector needs to know about the request in flight.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] single;
    ent_t       ent;
    logic [2:0] utf_len;
    logic [3:0] len;
    logic [3:0] ndig;
  } item_t;

  function automatic logic [3:0] entity_len(ent_t e);
    logic [3:0] n;
    begin
      unique case (e)
        E_LT, E_GT:     n = 4'd4;
        E_AMP:          n = 4'd5;
        E_APOS, E_QUOT: n = 4'd6;
        default:        n = 4'd4;
      endcase
      return n;
    end
  endfunction

  function automatic logic [7:0] entity_byte(ent_t e, logic [2:0] i);
    logic [47:0] w;
    logic [47:0] sh;
    begin
      unique case (e)
        E_LT:    w = {"&lt;", 16'h0};
        E_GT:    w = {"&gt;", 16'h0};
        E_AMP:   w = {"&amp;", 8'h0};
        E_APOS:  w = "&apos;";
        E_QUOT:  w = "&quot;";
        default: w = '0;
      endcase
      sh = w << {i, 3'b000};
      return sh[47:40];
    end
  endfunction

  // ISO-8859-15 replaces eight Latin-1 positions; those old positions map to '?'.
  function automatic logic [7:0] latin9_byte(logic signed [31:0] c);
    logic [7:0] b;
    begin
      if (c < 0) begin
        b = CH_QMARK;
      end else begin
        unique case (c)
          32'sh0000_20AC: b = 8'hA4;
          32'sh0000_0160: b = 8'hA6;
          32'sh0000_0161: b = 8'hA8;
          32'sh0000_017D: b = 8'hB4;
          32'sh0000_017E: b = 8'hB8;
          32'sh0000_0152: b = 8'hBC;
          32'sh0000_0153: b = 8'hBD;
          32'sh0000_0178: b = 8'hBE;
          32'sh0000_00A4, 32'sh0000_00A6, 32'sh0000_00A8, 32'sh0000_00B4,
          32'sh0000_00B8, 32'sh0000_00BC, 32'sh0000_00BD, 32'sh0000_00BE:
            b = CH_QMARK;
          default: b = (c > LATIN_MAX) ? CH_QMARK : c[7:0];
        endcase
      end
      return b;
    end
  endfunction

  function automatic logic [7:0] utf8_lead(logic [2:0] n);
    logic [7:0] b;
    begin
      unique case (n)
        3'd2:    b = 8'hC0;
        3'd3:    b = 8'hE0;
        3'd4:    b = 8'hF0;
        3'd5:    b = 8'hF8;
        3'd6:    b = 8'hFC;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

  function automatic logic [7:0] utf8_mask(logic [2:0] n);
    return 8'h7F >> n;
  endfunction

  function automatic logic [5:0] utf8_group(logic [BIN_BITS-1:0] u, logic [2:0] g);
    logic [5:0] r;
    begin
      unique case (g)
        3'd0:    r = u[5:0];
        3'd1:    r = u[11:6];
        3'd2:    r = u[17:12];
        3'd3:    r = u[23:18];
        3'd4:    r = u[29:24];
        3'd5:    r = {5'b0, u[30]};
        default: r = 6'b0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/core/ucse_bcd.sv
module ucse_bcd (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ucse_pkg::BIN_BITS-1:0]    bin,
  output logic                             done,
  output logic [ucse_pkg::BCD_BITS-1:0]    bcd
);
  import ucse_pkg::*;

  localparam int CNT_W = $clog2(BIN_BITS);

  logic [BIN_BITS-1:0] sreg;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [BCD_BITS-1:0] adj;

  // Shift-and-add-3: every digit of five or more is corrected before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(BIN_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(BIN_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= bin;
      bcd  <= '0;
    end else if (busy) begin
      sreg <= sreg << 1;
      bcd  <= {adj[BCD_BITS-2:0], sreg[BIN_BITS-1]};
    end
  end

endmodule

### rtl/core/ucse_byte_sel.sv
module ucse_byte_sel (
  input  ucse_pkg::item_t                  item,
  input  logic [3:0]                       idx,
  input  logic [ucse_pkg::BIN_BITS-1:0]    code,
  input  logic [ucse_pkg::BCD_BITS-1:0]    bcd,
  output logic [7:0]                       byte_out
);
  import ucse_pkg::*;

  logic [3:0] dpos;
  logic [3:0] digit;
  logic [2:0] grp_sel;
  logic [2:0] top_grp;
  logic [7:0] utf_byte;
  logic [7:0] num_byte;

  // Digits go out most significant first, after the "&#" prefix.
  always_comb begin
    dpos  = 4'(item.ndig + 4'd1 - idx);
    digit = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (dpos == 4'(i)) begin
        digit = bcd[4*i +: 4];
      end
    end
    if (idx == 4'd0) begin
      num_byte = CH_AMP;
    end else if (idx == 4'd1) begin
      num_byte = CH_HASH;
    end else if (idx == item.len - 4'd1) begin
      num_byte = CH_SEMI;
    end else begin
      num_byte = CH_ZERO | {4'b0, digit};
    end
  end

  always_comb begin
    top_grp = item.utf_len - 3'd1;
    grp_sel = 3'(4'(item.utf_len) - 4'd1 - idx);
    if (idx == 4'd0) begin
      utf_byte = utf8_lead(item.utf_len)
               | ({2'b0, utf8_group(code, top_grp)} & utf8_mask(item.utf_len));
    end else begin
      utf_byte = 8'h80 | {2'b0, utf8_group(code, grp_sel)};
    end
  end

  always_comb begin
    unique case (item.kind)
      K_SINGLE:  byte_out = item.single;
      K_ENTITY:  byte_out = entity_byte(item.ent, idx[2:0]);
      K_NUMERIC: byte_out = num_byte;
      K_UTF8:    byte_out = utf_byte;
      default:   byte_out = item.single;
    endcase
  end

endmodule

### rtl/core/ucs_char_output_encoder.sv
// Character output encoder: takes one signed 32-bit character code per request
// and returns its byte sequence in the selected encoding (Latin-1/ASCII,
// Latin-9, XML escaping or 1-to-6-byte UTF-8), one byte per output request,
// with last_byte set on the final byte. A negative code in UTF-8 mode gives no
// output at all. The block holds one character at a time and stalls its input
// until the previous character has been handed to the output register. An XML
// decimal entity first runs a 31-step shift-and-add-3 binary-to-decimal
// converter; such an entity has up to ten digits and 13 bytes. Output stalls
// hold back the byte sequence. Write output_encoding only while no character
// is in flight.
module ucs_char_output_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] code_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last_byte
);
  import ucse_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [1:0]          output_encoding;
  item_t               item;
  item_t               desc_in;
  logic [BIN_BITS-1:0] code;
  logic [3:0]          idx;
  logic                acc;
  logic                load;
  logic                conv_start;
  logic                bcd_done;
  logic [BCD_BITS-1:0] bcd;
  logic [3:0]          ndig;
  logic [7:0]          byte_next;
  logic                at_last;

  assign acc     = in_valid && !in_stall;
  assign at_last = (idx == item.len - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_encoding <= ENC_LATIN1;
    end else if (cfg_wr_en) begin
      output_encoding <= cfg_wr_data;
    end
  end

  // Classify the incoming code and work out its length where it is known now.
  always_comb begin
    desc_in         = '0;
    desc_in.kind    = K_SINGLE;
    desc_in.ent     = E_LT;
    desc_in.len     = 4'd1;
    unique case (output_encoding)
      ENC_LATIN1: begin
        desc_in.single = (code_point > LATIN_MAX) ? CH_QMARK : code_point[7:0];
      end
      ENC_LATIN9: begin
        desc_in.single = latin9_byte(code_point);
      end
      ENC_XML: begin
        priority if (code_point == {24'h0, CH_LT}) begin
          desc_in.kind = K_ENTITY;
          desc_in.ent  = E_LT;
        end else if (code_point == {24'h0, CH_GT}) begin
          desc_in.kind = K_ENTITY;
          desc_in.ent  = E_GT;
        end else if (code_point == {24'h0, CH_AMP}) begin
          desc_in.kind = K_ENTITY;
          desc_in.ent  = E_AMP;
        end else if (code_point == {24'h0, CH_APOS}) begin
          desc_in.kind = K_ENTITY;
          desc_in.ent  = E_APOS;
        end else if (code_point == {24'h0, CH_QUOT}) begin
          desc_in.kind = K_ENTITY;
          desc_in.ent  = E_QUOT;
        end else if (code_point < XML_NUM_START) begin
          desc_in.single = code_point[7:0];
        end else begin
          desc_in.kind = K_NUMERIC;
        end
        if (desc_in.kind == K_ENTITY) begin
          desc_in.len = entity_len(desc_in.ent);
        end
      end
      ENC_UTF8: begin
        priority if (code_point < 0) begin
          desc_in.len = 4'd0;
        end else if (code_point <= UTF8_MAX1) begin
          desc_in.single = code_point[7:0];
        end else begin
          desc_in.kind = K_UTF8;
          if (code_point <= UTF8_MAX2) begin
            desc_in.utf_len = 3'd2;
          end else if (code_point <= UTF8_MAX3) begin
            desc_in.utf_len = 3'd3;
          end else if (code_point <= UTF8_MAX4) begin
            desc_in.utf_len = 3'd4;
          end else if (code_point <= UTF8_MAX5) begin
            desc_in.utf_len = 3'd5;
          end else begin
            desc_in.utf_len = 3'd6;
          end
          desc_in.len = {1'b0, desc_in.utf_len};
        end
      end
      default: desc_in.single = code_point[7:0];
    endcase
  end

  // Number of significant decimal digits of the converted value.
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (desc_in.kind == K_NUMERIC) begin
            state_next = S_CONV;
          end else if (desc_in.len != 4'd0) begin
            state_next = S_EMIT;
          end
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load && at_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != S_IDLE);
    load       = (state == S_EMIT) && (!out_valid || !out_stall);
    conv_start = (state == S_IDLE) && acc && (desc_in.kind == K_NUMERIC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (acc) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item <= desc_in;
      code <= code_point[BIN_BITS-1:0];
    end else if (bcd_done) begin
      item.ndig <= ndig;
      item.len  <= ndig + 4'd3;
    end
    if (load) begin
      out_byte  <= byte_next;
      last_byte <= at_last;
    end
  end

  ucse_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .bin   (code_point[BIN_BITS-1:0]),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  ucse_byte_sel u_byte_sel (
    .item     (item),
    .idx      (idx),
    .code     (code),
    .bcd      (bcd),
    .byte_out (byte_next)
  );

  a_conv_done_in_conv : assert property (@(posedge clk) disable iff (rst)
    bcd_done |-> state == S_CONV)
    else $error("decimal converter finished outside the conversion state");

  a_idx_in_range : assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> idx < item.len && item.len <= 4'(MAX_SEQ))
    else $error("byte index past the end of the sequence");

  a_last_then_idle : assert property (@(posedge clk) disable iff (rst)
    load && at_last |=> state == S_IDLE && out_valid && last_byte)
    else $error("final byte did not end the sequence");

  a_numeric_converts : assert property (@(posedge clk) disable iff (rst)
    acc && desc_in.kind == K_NUMERIC |=> state == S_CONV)
    else $error("numeric entity request skipped the conversion");

endmodule
